FILE: rtl/ffpa_pkg.sv
`default_nettype none

package ffpa_pkg;

  localparam int FREE_SLOTS = 9;
  localparam int CNT_W      = $clog2(FREE_SLOTS + 1);

  localparam logic [23:0] POOL_CAP = 24'h800000;

  localparam logic OP_ALLOC = 1'b0;

  localparam logic [1:0] ST_GRANTED  = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_FREED    = 2'd2;
  localparam logic [1:0] ST_LEAKED   = 2'd3;

  typedef struct packed {
    logic [23:0] off;
    logic [23:0] size;
  } entry_t;

  typedef struct packed {
    logic   pop;
    logic   push;
    entry_t data;
  } list_cmd_t;

  typedef struct packed {
    logic [23:0] a;
    logic [23:0] b;
    logic [23:0] c;
    logic [23:0] d;
    logic [23:0] e;
    logic        sub;
  } alu_in_t;

  typedef struct packed {
    logic [24:0] sum;
    logic [24:0] res;
    logic        eq;
    logic        gt;
  } alu_out_t;

endpackage

`default_nettype wire

FILE: rtl/ffpa_alu.sv
`default_nettype none

module ffpa_alu import ffpa_pkg::*; (
  input  alu_in_t  alu_i,
  output alu_out_t alu_o
);

  logic [24:0] sum;

  assign sum = {1'b0, alu_i.a} + {1'b0, alu_i.b};

  always_comb begin
    alu_o.sum = sum;
    alu_o.res = alu_i.sub ? ({1'b0, alu_i.c} - {1'b0, alu_i.d})
                          : ({1'b0, alu_i.c} + {1'b0, alu_i.d});
    alu_o.eq  = (sum == {1'b0, alu_i.e});
    alu_o.gt  = (sum >  {1'b0, alu_i.e});
  end

endmodule

`default_nettype wire

FILE: rtl/ffpa_list.sv
`default_nettype none

module ffpa_list import ffpa_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  list_cmd_t        cmd_i,
  input  logic [23:0]      key_i,
  output entry_t           head_o,
  output logic [CNT_W-1:0] len_o,
  output logic [CNT_W-1:0] pos_o
);

  entry_t           ent_q [FREE_SLOTS];
  entry_t           ent_d [FREE_SLOTS];
  logic [CNT_W-1:0] len_q;
  logic [CNT_W-1:0] len_d;
  logic [CNT_W-1:0] widx;

  assign widx  = cmd_i.pop ? (len_q - CNT_W'(1)) : len_q;
  assign len_d = len_q + CNT_W'(cmd_i.push) - CNT_W'(cmd_i.pop);

  for (genvar g = 0; g < FREE_SLOTS; g++) begin : g_slot
    entry_t shifted;
    if (g < FREE_SLOTS - 1) begin : g_mid
      assign shifted = cmd_i.pop ? ent_q[g+1] : ent_q[g];
    end else begin : g_last
      assign shifted = ent_q[g];
    end
    always_comb begin
      ent_d[g] = shifted;
      if (cmd_i.push && (widx == CNT_W'(g))) begin
        ent_d[g] = cmd_i.data;
      end
    end
    always_ff @(posedge clk_i) begin
      ent_q[g] <= ent_d[g];
    end
  end

  // place a new entry after the last one whose offset does not exceed the key
  always_comb begin
    pos_o = '0;
    for (int j = 0; j < FREE_SLOTS; j++) begin
      if ((CNT_W'(j) < len_q) && (ent_q[j].off <= key_i)) begin
        pos_o = CNT_W'(j + 1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else begin
      len_q <= len_d;
    end
  end

  assign head_o = ent_q[0];
  assign len_o  = len_q;

endmodule

`default_nettype wire

FILE: rtl/first_fit_pool_allocator_unit.sv
// Allocate walks the whole free list, then tries the bump pointer if no entry fits;
// free walks and merges the list; free into a full list (9 entries) reports leaked.
// One request at a time; tready returns on the edge that loads the result register,
// so a request holds the unit through the list walk and any output stall.
// Reset: free list empty, bump pointer 0, pool_limit 8388608, output valid low.
`default_nettype none

module first_fit_pool_allocator_unit import ffpa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // [23:0] block_size, [46:24] block_offset, [47] zero
  input  logic        s_axis_tuser,   // [0] operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [22:0] granted_offset, [23] zero
  output logic [1:0]  m_axis_tuser,   // [1:0] status
  input  logic        cfg_wr_en,
  input  logic [23:0] cfg_wr_data     // [23:0] pool_limit
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC,
    S_BUMP,
    S_FREE,
    S_FLUSH,
    S_DONE
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] rem_q, rem_d;
  logic [23:0]      size_q, size_d;
  logic [23:0]      off_q, off_d;
  logic             found_q, found_d;
  logic             ins_q, ins_d;
  entry_t           acc_q, acc_d;
  logic             acc_vld_q, acc_vld_d;
  logic [1:0]       status_q, status_d;
  logic [22:0]      grant_q, grant_d;
  logic [23:0]      bump_q, bump_d;
  logic [23:0]      limit_q, limit_d;
  logic             m_valid_q, m_valid_d;
  logic [1:0]       m_status_q, m_status_d;
  logic [22:0]      m_grant_q, m_grant_d;

  list_cmd_t        list_cmd;
  entry_t           head;
  logic [CNT_W-1:0] len;
  logic [CNT_W-1:0] ins_pos;
  alu_in_t          alu_in;
  alu_out_t         alu_out;
  logic             feed_head;
  entry_t           feed;
  logic [23:0]      lim_eff;
  logic             fit;
  logic             exact;

  ffpa_list u_list (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (list_cmd),
    .key_i  ({1'b0, s_axis_tdata[46:24]}),
    .head_o (head),
    .len_o  (len),
    .pos_o  (ins_pos)
  );

  ffpa_alu u_alu (
    .alu_i (alu_in),
    .alu_o (alu_out)
  );

  assign lim_eff   = (limit_q > POOL_CAP) ? POOL_CAP : limit_q;
  assign feed_head = (cnt_q != '0) && (ins_q || (rem_q != '0));
  assign feed      = feed_head ? head : entry_t'{off: off_q, size: size_q};
  assign fit       = !alu_out.res[24];
  assign exact     = (alu_out.res == '0);

  always_comb begin
    alu_in = '0;
    unique case (state_q)
      S_BUMP: begin
        alu_in.a   = bump_q;
        alu_in.b   = size_q;
        alu_in.e   = lim_eff;
        alu_in.sub = 1'b1;
      end
      S_FREE: begin
        alu_in.a   = acc_q.off;
        alu_in.b   = acc_q.size;
        alu_in.c   = acc_q.size;
        alu_in.d   = feed.size;
        alu_in.e   = feed.off;
        alu_in.sub = 1'b0;
      end
      default: begin
        alu_in.a   = head.off;
        alu_in.b   = size_q;
        alu_in.c   = head.size;
        alu_in.d   = size_q;
        alu_in.sub = 1'b1;
      end
    endcase
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    rem_d      = rem_q;
    size_d     = size_q;
    off_d      = off_q;
    found_d    = found_q;
    ins_d      = ins_q;
    acc_d      = acc_q;
    acc_vld_d  = acc_vld_q;
    status_d   = status_q;
    grant_d    = grant_q;
    bump_d     = bump_q;
    limit_d    = cfg_wr_en ? cfg_wr_data : limit_q;
    m_valid_d  = m_valid_q && !m_axis_tready;
    m_status_d = m_status_q;
    m_grant_d  = m_grant_q;
    list_cmd   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          size_d    = s_axis_tdata[23:0];
          off_d     = {1'b0, s_axis_tdata[46:24]};
          cnt_d     = len;
          rem_d     = ins_pos;
          found_d   = 1'b0;
          ins_d     = 1'b0;
          acc_vld_d = 1'b0;
          grant_d   = '0;
          if (s_axis_tuser == OP_ALLOC) begin
            state_d = S_ALLOC;
          end else if (len >= CNT_W'(FREE_SLOTS)) begin
            status_d = ST_LEAKED;
            state_d  = S_DONE;
          end else begin
            state_d = S_FREE;
          end
        end
      end
      S_ALLOC: begin
        if (cnt_q == '0) begin
          if (found_q) begin
            status_d = ST_GRANTED;
            state_d  = S_DONE;
          end else begin
            state_d = S_BUMP;
          end
        end else begin
          list_cmd.pop = 1'b1;
          cnt_d        = cnt_q - CNT_W'(1);
          if (!found_q && fit) begin
            found_d = 1'b1;
            grant_d = head.off[22:0];
            if (!exact) begin
              list_cmd.push      = 1'b1;
              list_cmd.data.off  = alu_out.sum[23:0];
              list_cmd.data.size = alu_out.res[23:0];
            end
          end else begin
            list_cmd.push = 1'b1;
            list_cmd.data = head;
          end
        end
      end
      S_BUMP: begin
        if (alu_out.gt) begin
          status_d = ST_NO_SPACE;
          grant_d  = '0;
        end else begin
          status_d = ST_GRANTED;
          grant_d  = bump_q[22:0];
          bump_d   = alu_out.sum[23:0];
        end
        state_d = S_DONE;
      end
      S_FREE: begin
        if ((cnt_q == '0) && ins_q) begin
          state_d = S_FLUSH;
        end else begin
          if (feed_head) begin
            list_cmd.pop = 1'b1;
            cnt_d        = cnt_q - CNT_W'(1);
            if (rem_q != '0) begin
              rem_d = rem_q - CNT_W'(1);
            end
          end else begin
            ins_d = 1'b1;
          end
          if (acc_vld_q && alu_out.eq) begin
            acc_d.size = alu_out.res[24] ? '1 : alu_out.res[23:0];
          end else begin
            if (acc_vld_q) begin
              list_cmd.push = 1'b1;
              list_cmd.data = acc_q;
            end
            acc_d     = feed;
            acc_vld_d = 1'b1;
          end
        end
      end
      S_FLUSH: begin
        list_cmd.push = 1'b1;
        list_cmd.data = acc_q;
        status_d      = ST_FREED;
        state_d       = S_DONE;
      end
      S_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d  = 1'b1;
          m_status_d = status_q;
          m_grant_d  = grant_q;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      found_q   <= 1'b0;
      ins_q     <= 1'b0;
      acc_vld_q <= 1'b0;
      bump_q    <= '0;
      limit_q   <= POOL_CAP;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      found_q   <= found_d;
      ins_q     <= ins_d;
      acc_vld_q <= acc_vld_d;
      bump_q    <= bump_d;
      limit_q   <= limit_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    size_q     <= size_d;
    off_q      <= off_d;
    rem_q      <= rem_d;
    acc_q      <= acc_d;
    status_q   <= status_d;
    grant_q    <= grant_d;
    m_status_q <= m_status_d;
    m_grant_q  <= m_grant_d;
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {1'b0, m_grant_q};
  assign m_axis_tuser  = m_status_q;

endmodule

`default_nettype wire

FILE: rtl/ffpa_checker.sv
`default_nettype none

module ffpa_checker import ffpa_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [23:0] out_data_i,
  input logic [1:0]  out_user_i
);

  // hold off new requests while one is in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("request accepted while another is in flight");

  // drive a zero offset on every result that is not a grant
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && (out_user_i != ST_GRANTED)) |-> (out_data_i == '0))
    else $error("nonzero offset on a result that is not a grant");

  // hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(out_data_i) && $stable(out_user_i)))
    else $error("stalled result changed");

endmodule

bind first_fit_pool_allocator_unit ffpa_checker u_ffpa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (s_axis_tvalid),
  .in_ready_i  (s_axis_tready),
  .out_valid_i (m_axis_tvalid),
  .out_ready_i (m_axis_tready),
  .out_data_i  (m_axis_tdata),
  .out_user_i  (m_axis_tuser)
);

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import ffpa_pkg::*;

  localparam logic OP_FREE = ~OP_ALLOC;
  localparam int IDLE_LIMIT = 2000;
  localparam int RANDOM_PHASES = 5;
  localparam int PHASE_REQUESTS = 280;
  localparam int SETTLE_CYCLES = 16;
  localparam int LONG_HOLD = 400;
  localparam int DIRECTED_ROWS = 25;

  typedef struct packed {
    logic [1:0]  status;
    logic [22:0] granted;
  } alloc_result_t;

  typedef struct packed {
    logic [22:0] off;
    logic [23:0] size;
  } live_block_t;

  typedef struct packed {
    logic        op;
    logic [23:0] size;
    logic [22:0] off;
    logic        typed;
    logic [1:0]  status;
    logic [22:0] granted;
  } directed_row_t;

  localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{OP_ALLOC, 24'd0,      23'd0,      1'b1, ST_GRANTED,  23'd0},
    '{OP_FREE,  24'h800000, 23'h7FFFFF, 1'b1, ST_FREED,    23'd0},
    '{OP_ALLOC, 24'd1,      23'd0,      1'b1, ST_GRANTED,  23'h7FFFFF},
    '{OP_ALLOC, 24'd1,      23'h7FFFFF, 1'b0, ST_GRANTED,  23'd0},
    '{OP_ALLOC, 24'h7FFFFE, 23'd0,      1'b0, ST_GRANTED,  23'd0},
    '{OP_ALLOC, 24'h40,     23'd0,      1'b1, ST_GRANTED,  23'd0},
    '{OP_FREE,  24'd50,     23'd100,    1'b1, ST_FREED,    23'd0},
    '{OP_FREE,  24'd50,     23'd150,    1'b1, ST_FREED,    23'd0},
    '{OP_FREE,  24'd50,     23'd50,     1'b1, ST_FREED,    23'd0},
    '{OP_FREE,  24'd0,      23'd300,    1'b1, ST_FREED,    23'd0},
    '{OP_FREE,  24'd20,     23'd300,    1'b1, ST_FREED,    23'd0},
    '{OP_ALLOC, 24'd0,      23'd0,      1'b0, ST_GRANTED,  23'd0},
    '{OP_ALLOC, 24'd150,    23'd0,      1'b0, ST_GRANTED,  23'd0},
    '{OP_ALLOC, 24'd10,     23'd0,      1'b0, ST_GRANTED,  23'd0},
    '{OP_ALLOC, 24'd11,     23'd0,      1'b0, ST_GRANTED,  23'd0},
    '{OP_ALLOC, 24'h800000, 23'd0,      1'b1, ST_NO_SPACE, 23'd0},
    '{OP_FREE,  24'd1,      23'd1000,   1'b1, ST_FREED,    23'd0},
    '{OP_FREE,  24'd1,      23'd2000,   1'b1, ST_FREED,    23'd0},
    '{OP_FREE,  24'd1,      23'd3000,   1'b1, ST_FREED,    23'd0},
    '{OP_FREE,  24'd1,      23'd4000,   1'b1, ST_FREED,    23'd0},
    '{OP_FREE,  24'd1,      23'd5000,   1'b1, ST_FREED,    23'd0},
    '{OP_FREE,  24'd1,      23'd6000,   1'b1, ST_FREED,    23'd0},
    '{OP_FREE,  24'd1,      23'd7000,   1'b1, ST_FREED,    23'd0},
    '{OP_FREE,  24'd1,      23'd8000,   1'b1, ST_FREED,    23'd0},
    '{OP_FREE,  24'd1,      23'd9000,   1'b1, ST_LEAKED,   23'd0}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        cfg_wr_en;
  logic [23:0] cfg_wr_data;

  logic [23:0]   pool_off [FREE_SLOTS];
  logic [23:0]   pool_sz [FREE_SLOTS];
  int unsigned   pool_cnt;
  logic [23:0]   bump_ptr;
  logic [23:0]   pool_limit_q;

  alloc_result_t pending_results[$];
  live_block_t   live_blocks[$];
  alloc_result_t oldest;
  int            fail_cnt;
  int            sent_cnt;
  int            status_seen [4];
  int            quiet_cycles;
  int            hold_cnt;
  bit            sink_calm;
  bit            feed_calm;
  bit            long_hold_req;

  first_fit_pool_allocator_unit uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(0, 2);
    if (r < 95) return $urandom_range(3, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic void drop_free_entry(int k);
    for (int j = k; j + 1 < pool_cnt; j++) begin
      pool_off[j] = pool_off[j + 1];
      pool_sz[j]  = pool_sz[j + 1];
    end
    pool_cnt--;
  endfunction

  function automatic alloc_result_t next_alloc_result(logic op, logic [23:0] size,
                                                      logic [22:0] off);
    alloc_result_t res;
    logic [23:0]   lim;
    logic [23:0]   tmp_off;
    logic [23:0]   tmp_sz;
    logic [24:0]   sum;
    bit            hit;
    int            i;
    res = '0;
    hit = 1'b0;
    if (op == OP_ALLOC) begin
      for (i = 0; i < pool_cnt && !hit; i++) begin
        if (pool_sz[i] >= size) begin
          hit = 1'b1;
          res.status  = ST_GRANTED;
          res.granted = pool_off[i][22:0];
          if (pool_sz[i] == size) begin
            drop_free_entry(i);
          end else begin
            pool_off[i] = pool_off[i] + size;
            pool_sz[i]  = pool_sz[i] - size;
          end
        end
      end
      if (!hit) begin
        lim = (pool_limit_q > POOL_CAP) ? POOL_CAP : pool_limit_q;
        if ({1'b0, bump_ptr} + size > {1'b0, lim}) begin
          res.status = ST_NO_SPACE;
        end else begin
          res.status  = ST_GRANTED;
          res.granted = bump_ptr[22:0];
          bump_ptr    = bump_ptr + size;
        end
      end
    end else if (pool_cnt >= FREE_SLOTS) begin
      res.status = ST_LEAKED;
    end else begin
      res.status = ST_FREED;
      pool_off[pool_cnt] = {1'b0, off};
      pool_sz[pool_cnt]  = size;
      pool_cnt++;
      i = pool_cnt - 1;
      while (i > 0 && pool_off[i] < pool_off[i - 1]) begin
        tmp_off         = pool_off[i];
        tmp_sz          = pool_sz[i];
        pool_off[i]     = pool_off[i - 1];
        pool_sz[i]      = pool_sz[i - 1];
        pool_off[i - 1] = tmp_off;
        pool_sz[i - 1]  = tmp_sz;
        i--;
      end
      i = 0;
      while (i + 1 < pool_cnt) begin
        sum = {1'b0, pool_off[i]} + pool_sz[i];
        if (sum == {1'b0, pool_off[i + 1]}) begin
          sum = {1'b0, pool_sz[i]} + pool_sz[i + 1];
          pool_sz[i] = sum[24] ? 24'hFFFFFF : sum[23:0];
          drop_free_entry(i + 1);
        end else begin
          i++;
        end
      end
    end
    return res;
  endfunction

  task automatic offer_request(logic op, logic [23:0] size, logic [22:0] off,
                               logic typed, alloc_result_t typed_res);
    alloc_result_t res;
    int            gap;
    if ($urandom_range(0, 59) == 0) feed_calm = !feed_calm;
    gap = feed_calm ? 0 : pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {1'b0, off, size};
    s_axis_tuser  = op;
    forever begin
      @(posedge clk_i);
      if (s_axis_tready) break;
    end
    res = next_alloc_result(op, size, off);
    if (op == OP_ALLOC && res.status == ST_GRANTED && size != 0) begin
      live_blocks.push_back('{res.granted, size});
    end
    pending_results.push_back(typed ? typed_res : res);
    sent_cnt++;
  endtask

  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [23:0] value);
    @(negedge clk_i);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = value;
    @(negedge clk_i);
    cfg_wr_en   = 1'b0;
    pool_limit_q = value;
  endtask

  task automatic random_request();
    logic        op;
    logic [23:0] size;
    logic [22:0] off;
    live_block_t blk;
    int          r;
    int          k;
    off = 23'($urandom_range(0, 23'h7FFFFF));
    r   = $urandom_range(0, 99);
    if (r < 50) begin
      op = OP_ALLOC;
      r  = $urandom_range(0, 99);
      if (r < 10 && pool_cnt != 0) begin
        k    = $urandom_range(0, pool_cnt - 1);
        size = pool_sz[k];
        case ($urandom_range(0, 2))
          0: size = size + 24'd1;
          1: if (size != 0) size = size - 24'd1;
          default: ;
        endcase
      end else if (r < 15) begin
        size = '0;
      end else if (r < 17) begin
        size = 24'($urandom_range(24'h400000, 24'h800000));
      end else if (r < 35) begin
        size = 24'($urandom_range(257, 16383));
      end else begin
        size = 24'($urandom_range(1, 256));
      end
      if (size > POOL_CAP) size = POOL_CAP;
    end else if (r < 88 && live_blocks.size() != 0) begin
      op   = OP_FREE;
      k    = $urandom_range(0, live_blocks.size() - 1);
      blk  = live_blocks[k];
      live_blocks.delete(k);
      off  = blk.off;
      size = blk.size;
    end else begin
      op   = OP_FREE;
      size = ($urandom_range(0, 3) == 0) ? 24'($urandom_range(0, 24'h800000))
                                         : 24'($urandom_range(0, 16));
    end
    offer_request(op, size, off, 1'b0, '0);
  endtask

  initial begin
    m_axis_tready = 1'b0;
    hold_cnt      = 0;
    sink_calm     = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_cnt      = LONG_HOLD;
      end
      if ($urandom_range(0, 149) == 0) sink_calm = !sink_calm;
      if (hold_cnt > 0) begin
        m_axis_tready = 1'b0;
        hold_cnt--;
      end else begin
        m_axis_tready = 1'b1;
        if (!sink_calm && $urandom_range(0, 2) == 0) hold_cnt = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d, granted_offset 0x%0h",
               m_axis_tuser, m_axis_tdata[22:0]);
        fail_cnt++;
      end else begin
        oldest = pending_results.pop_front();
        status_seen[m_axis_tuser]++;
        if (m_axis_tuser !== oldest.status) begin
          $error("status: expected %0d, got %0d", oldest.status, m_axis_tuser);
          fail_cnt++;
        end
        if (m_axis_tdata[22:0] !== oldest.granted) begin
          $error("granted_offset: expected 0x%0h, got 0x%0h", oldest.granted,
                 m_axis_tdata[22:0]);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("[first_fit_pool_allocator_unit] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int          p;
    int          n;
    logic [23:0] lim;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_ALLOC;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    fail_cnt      = 0;
    sent_cnt      = 0;
    quiet_cycles  = 0;
    feed_calm     = 1'b0;
    long_hold_req = 1'b0;
    status_seen   = '{0, 0, 0, 0};
    pool_cnt      = 0;
    bump_ptr      = '0;
    pool_limit_q  = POOL_CAP;
    for (int i = 0; i < FREE_SLOTS; i++) begin
      pool_off[i] = '0;
      pool_sz[i]  = '0;
    end
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      offer_request(DIRECTED[i].op, DIRECTED[i].size, DIRECTED[i].off, DIRECTED[i].typed,
                    {DIRECTED[i].status, DIRECTED[i].granted});
    end
    settle();

    for (p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0:       lim = 24'hFFFFFF;
        1:       lim = '0;
        2:       lim = 24'($urandom_range(0, 24'hFFFFFF));
        3:       lim = POOL_CAP;
        default: lim = bump_ptr + 24'($urandom_range(0, 24'h080000));
      endcase
      write_limit(lim);
      for (n = 0; n < PHASE_REQUESTS; n++) begin
        if (p == 2 && n == PHASE_REQUESTS / 2) long_hold_req = 1'b1;
        random_request();
      end
      settle();
    end

    // drain the free list, then run the bump pointer into the pool cap
    while (pool_cnt != 0) offer_request(OP_ALLOC, pool_sz[0], '0, 1'b0, '0);
    settle();
    write_limit(24'hFFFFFF);
    offer_request(OP_ALLOC, POOL_CAP - bump_ptr, '0, 1'b0, '0);
    offer_request(OP_ALLOC, 24'd1, '0, 1'b0, '0);
    offer_request(OP_ALLOC, 24'd0, '0, 1'b0, '0);
    settle();

    $display("Sent %0d requests: %0d granted, %0d out of space, %0d freed, %0d dropped.",
             sent_cnt, status_seen[ST_GRANTED], status_seen[ST_NO_SPACE],
             status_seen[ST_FREED], status_seen[ST_LEAKED]);
    $display("Pool limit changed %0d times, including zero and values above the pool cap.",
             RANDOM_PHASES + 1);
    if (fail_cnt == 0) begin
      $display("[first_fit_pool_allocator_unit] OK");
    end else begin
      $display("[first_fit_pool_allocator_unit] ERROR");
    end
    $finish;
  end

endmodule
